// ===== rtl/core/nrbh_pkg.sv =====
// ----------------------------------------------------------------------------
// nrbh_pkg
// Shared types and constants for the nearest ray/box hit block.
// ----------------------------------------------------------------------------
package nrbh_pkg;

    localparam int DEF_MAX_BOXES = 64;
    localparam int DEF_COORD_W   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int DIST_W        = 31;
    localparam int T_W           = DIST_W + 1;
    localparam int QUO_STEPS     = DIST_W;
    localparam logic [DIST_W-1:0] T_HUGE = {DIST_W{1'b1}};

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_CAST   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_AXIS,
        S_DIV,
        S_COMB,
        S_BOXEND,
        S_NEXT,
        S_RESULT
    } state_t;

endpackage

// ===== rtl/core/nrbh_div.sv =====
// ----------------------------------------------------------------------------
// nrbh_div
// Signed Q16.16 divider, one quotient bit per cycle, saturating to T_HUGE.
// ----------------------------------------------------------------------------
module nrbh_div #(
    parameter int COORD_WIDTH = nrbh_pkg::DEF_COORD_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_WIDTH:0]   num,
    input  logic signed [COORD_WIDTH-1:0] den,
    output logic                          done,
    output logic signed [nrbh_pkg::T_W-1:0] quo
);
    import nrbh_pkg::*;

    localparam int CNT_W = $clog2(QUO_STEPS);
    localparam int CMP_W = COORD_WIDTH + FRAC_BITS;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   neg_reg, neg_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [COORD_WIDTH-1:0] rem_reg, rem_next;
    logic [COORD_WIDTH-1:0] dmag_reg, dmag_next;
    logic [DIST_W-1:0]      low_reg, low_next;
    logic [DIST_W-1:0]      q_reg, q_next;

    logic [COORD_WIDTH:0]   nmag;
    logic [COORD_WIDTH-1:0] dmag;
    logic [CMP_W-1:0]       n_cmp, d_cmp;
    logic [COORD_WIDTH:0]   trial;
    logic                   qbit;

    always_comb
    begin
        nmag  = num[COORD_WIDTH] ? (~num + 1'b1) : num;
        dmag  = den[COORD_WIDTH-1] ? (~den + 1'b1) : den;
        n_cmp = CMP_W'(nmag);
        d_cmp = CMP_W'(dmag) << (FRAC_BITS - 1);
        trial = {rem_reg, low_reg[DIST_W-1]};
        qbit  = (trial >= {1'b0, dmag_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        if (start)
        begin
            neg_next  = num[COORD_WIDTH] ^ den[COORD_WIDTH-1];
            dmag_next = dmag;
            cnt_next  = '0;
            if (n_cmp >= d_cmp)
            begin
                q_next    = T_HUGE;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                rem_next  = COORD_WIDTH'(nmag >> (FRAC_BITS - 1));
                low_next  = {nmag[FRAC_BITS-2:0], {FRAC_BITS{1'b0}}};
                q_next    = '0;
            end
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? COORD_WIDTH'(trial - {1'b0, dmag_reg})
                            : COORD_WIDTH'(trial);
            low_next = {low_reg[DIST_W-2:0], 1'b0};
            q_next   = {q_reg[DIST_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

// ===== rtl/core/nearest_ray_box_hit.sv =====
// ----------------------------------------------------------------------------
// nearest_ray_box_hit
// Box table with clear, add and cast; a cast reports the nearest slab hit.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, action, coord_*, max_t | into block
//  out     | out_valid, out_ready, distance, hit, ...   | out of block
//
//  Clear and add go from idle straight to the result state. A cast walks the
//  N stored boxes in turn: each nonzero axis runs two 31-step divisions
//  on the single shared divider, which sets the rate; a saturating quotient,
//  a zero direction or an early miss ends sooner.
//  Reset empties the table at once; box memory needs no clearing pass.
//  A new word is taken while the previous result still waits on out.
// ----------------------------------------------------------------------------
module nearest_ray_box_hit #(
    parameter int MAX_BOXES   = nrbh_pkg::DEF_MAX_BOXES,
    parameter int COORD_WIDTH = nrbh_pkg::DEF_COORD_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     action,
    input  logic signed [COORD_WIDTH-1:0]  coord_a_x,
    input  logic signed [COORD_WIDTH-1:0]  coord_a_y,
    input  logic signed [COORD_WIDTH-1:0]  coord_a_z,
    input  logic signed [COORD_WIDTH-1:0]  coord_b_x,
    input  logic signed [COORD_WIDTH-1:0]  coord_b_y,
    input  logic signed [COORD_WIDTH-1:0]  coord_b_z,
    input  logic [nrbh_pkg::DIST_W-1:0]    max_t,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [nrbh_pkg::DIST_W-1:0]    distance,
    output logic                           hit,
    output logic                           table_full
);
    import nrbh_pkg::*;

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int CW    = COORD_WIDTH;
    localparam int WORD_W = 6 * CW;

    logic [WORD_W-1:0] box_mem [MAX_BOXES];
    logic [WORD_W-1:0] mem_q;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     box_idx_reg, box_idx_next;
    logic [1:0]           axis_reg, axis_next;
    logic                 half_reg, half_next;
    logic signed [T_W-1:0] entry_reg, entry_next;
    logic signed [T_W-1:0] exit_reg, exit_next;
    logic signed [T_W-1:0] t1_reg, t1_next;
    logic signed [T_W-1:0] t2_reg, t2_next;
    logic [DIST_W-1:0]    nearest_reg, nearest_next;
    logic [DIST_W-1:0]    maxt_reg, maxt_next;
    logic                 full_reg, full_next;
    logic signed [CW-1:0] org_reg [3];
    logic signed [CW-1:0] org_next [3];
    logic signed [CW-1:0] dir_reg [3];
    logic signed [CW-1:0] dir_next [3];
    logic                 out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]    dist_reg, dist_next;
    logic                 hit_reg, hit_next;
    logic                 tfull_reg, tfull_next;

    logic                 accept;
    logic                 wr_en;
    logic                 rd_en;
    logic                 slot_free;
    logic                 last_box;
    logic                 not_full;
    logic signed [CW-1:0] sel_o, sel_d, sel_lo, sel_hi;
    logic signed [T_W-1:0] t_lo, t_hi, ent_c, ext_c;
    logic                 div_start;
    logic                 div_done;
    logic signed [CW:0]   div_num;
    logic signed [T_W-1:0] div_quo;

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign not_full  = (count_reg < CNT_W'(MAX_BOXES));
    assign wr_en     = accept && (action == ACT_ADD) && not_full;
    assign last_box  = ((CNT_W'(box_idx_reg) + CNT_W'(1)) == count_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            box_mem[count_reg[IDX_W-1:0]] <= {coord_a_x, coord_a_y, coord_a_z,
                                              coord_b_x, coord_b_y, coord_b_z};
        end
        if (rd_en)
        begin
            mem_q <= box_mem[box_idx_reg];
        end
    end

    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                sel_lo = mem_q[6*CW-1:5*CW];
                sel_hi = mem_q[3*CW-1:2*CW];
            end
            2'd1:
            begin
                sel_lo = mem_q[5*CW-1:4*CW];
                sel_hi = mem_q[2*CW-1:CW];
            end
            default:
            begin
                sel_lo = mem_q[4*CW-1:3*CW];
                sel_hi = mem_q[CW-1:0];
            end
        endcase
        sel_o = org_reg[axis_reg];
        sel_d = dir_reg[axis_reg];
        t_lo  = (t1_reg > t2_reg) ? t2_reg : t1_reg;
        t_hi  = (t1_reg > t2_reg) ? t1_reg : t2_reg;
        ent_c = (t_lo > entry_reg) ? t_lo : entry_reg;
        ext_c = (t_hi < exit_reg) ? t_hi : exit_reg;
    end

    nrbh_div #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (sel_d),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_CAST && count_reg != '0)
                        state_next = S_FETCH;
                    else
                        state_next = S_RESULT;
                end
            end
            S_FETCH:  state_next = S_AXIS;
            S_AXIS:
            begin
                if (sel_d == '0)
                begin
                    if (sel_o < sel_lo || sel_o > sel_hi)
                        state_next = S_NEXT;
                    else if (axis_reg == 2'd2)
                        state_next = S_BOXEND;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done && half_reg)
                    state_next = S_COMB;
            end
            S_COMB:
            begin
                if (ent_c > ext_c)
                    state_next = S_NEXT;
                else if (axis_reg == 2'd2)
                    state_next = S_BOXEND;
                else
                    state_next = S_AXIS;
            end
            S_BOXEND: state_next = S_NEXT;
            S_NEXT:   state_next = last_box ? S_RESULT : S_FETCH;
            S_RESULT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        rd_en     = (state_reg == S_FETCH);
        div_start = 1'b0;
        div_num   = {sel_lo[CW-1], sel_lo} - {sel_o[CW-1], sel_o};
        case (state_reg)
            S_AXIS:
            begin
                div_start = (sel_d != '0);
            end
            S_DIV:
            begin
                div_start = div_done && !half_reg;
                div_num   = {sel_hi[CW-1], sel_hi} - {sel_o[CW-1], sel_o};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        box_idx_next   = box_idx_reg;
        axis_next      = axis_reg;
        half_next      = half_reg;
        entry_next     = entry_reg;
        exit_next      = exit_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        nearest_next   = nearest_reg;
        maxt_next      = maxt_reg;
        full_next      = full_reg;
        org_next       = org_reg;
        dir_next       = dir_reg;
        out_valid_next = out_valid_reg;
        dist_next      = dist_reg;
        hit_next       = hit_reg;
        tfull_next     = tfull_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    org_next     = '{coord_a_x, coord_a_y, coord_a_z};
                    dir_next     = '{coord_b_x, coord_b_y, coord_b_z};
                    box_idx_next = '0;
                    full_next    = 1'b0;
                    nearest_next = '0;
                    maxt_next    = '0;
                    if (action == ACT_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (action == ACT_ADD)
                    begin
                        if (not_full)
                            count_next = count_reg + 1'b1;
                        else
                            full_next = 1'b1;
                    end
                    else if (action == ACT_CAST)
                    begin
                        nearest_next = max_t;
                        maxt_next    = max_t;
                    end
                end
            end
            S_FETCH:
            begin
                axis_next  = 2'd0;
                entry_next = '0;
                exit_next  = $signed({1'b0, T_HUGE});
            end
            S_AXIS:
            begin
                half_next = 1'b0;
                if (sel_d == '0)
                    axis_next = axis_reg + 1'b1;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (half_reg)
                    begin
                        t2_next = div_quo;
                    end
                    else
                    begin
                        t1_next   = div_quo;
                        half_next = 1'b1;
                    end
                end
            end
            S_COMB:
            begin
                entry_next = ent_c;
                exit_next  = ext_c;
                axis_next  = axis_reg + 1'b1;
            end
            S_BOXEND:
            begin
                if (!entry_reg[T_W-1] && entry_reg[DIST_W-1:0] < nearest_reg)
                    nearest_next = entry_reg[DIST_W-1:0];
            end
            S_NEXT:
            begin
                box_idx_next = box_idx_reg + 1'b1;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    dist_next      = nearest_reg;
                    hit_next       = (nearest_reg < maxt_reg);
                    tfull_next     = full_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_idx_reg <= box_idx_next;
        axis_reg    <= axis_next;
        half_reg    <= half_next;
        entry_reg   <= entry_next;
        exit_reg    <= exit_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        nearest_reg <= nearest_next;
        maxt_reg    <= maxt_next;
        full_reg    <= full_next;
        org_reg     <= org_next;
        dir_reg     <= dir_next;
        dist_reg    <= dist_next;
        hit_reg     <= hit_next;
        tfull_reg   <= tfull_next;
    end

    assign out_valid  = out_valid_reg;
    assign distance   = dist_reg;
    assign hit        = hit_reg;
    assign table_full = tfull_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BOXES))
        else $error("box count above table size");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside a division");

    a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> (CNT_W'(box_idx_reg) < count_reg))
        else $error("fetch beyond stored boxes");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && slot_free) |=> (out_valid && state_reg == S_IDLE))
        else $error("result not presented");

endmodule

// ===== bench/nrbh_checker.sv =====
// ----------------------------------------------------------------------------
// nrbh_checker
// Watches both channels of the nearest ray/box hit block, keeps its own box
// table, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module nrbh_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [1:0]                           action,
    input  logic signed [nrbh_pkg::DEF_COORD_W-1:0] coord_a_x,
    input  logic signed [nrbh_pkg::DEF_COORD_W-1:0] coord_a_y,
    input  logic signed [nrbh_pkg::DEF_COORD_W-1:0] coord_a_z,
    input  logic signed [nrbh_pkg::DEF_COORD_W-1:0] coord_b_x,
    input  logic signed [nrbh_pkg::DEF_COORD_W-1:0] coord_b_y,
    input  logic signed [nrbh_pkg::DEF_COORD_W-1:0] coord_b_z,
    input  logic [nrbh_pkg::DIST_W-1:0]          max_t,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [nrbh_pkg::DIST_W-1:0]          distance,
    input  logic                                 hit,
    input  logic                                 table_full,
    output int                                   errors,
    output int                                   pending
);
    import nrbh_pkg::*;

    localparam int    NBOX = DEF_MAX_BOXES;
    localparam longint HUGE = 64'h7FFF_FFFF;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              hit;
        logic              table_full;
    } hit_word_t;

    longint    lo_x[NBOX], lo_y[NBOX], lo_z[NBOX];
    longint    hi_x[NBOX], hi_y[NBOX], hi_z[NBOX];
    int        stored;
    hit_word_t expected_hits[$];

    assign pending = expected_hits.size();

    function automatic longint slab_quotient(longint num, longint den);
        longint n, d, q, r, res;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        r = n % d;
        if (q > (HUGE >>> FRAC_BITS))
            res = HUGE;
        else
        begin
            res = (q <<< FRAC_BITS) + ((r <<< FRAC_BITS) / d);
            if (res > HUGE)
                res = HUGE;
        end
        return ((num < 0) != (den < 0)) ? -res : res;
    endfunction

    function automatic bit slab_pass(longint o, longint d, longint lo, longint hi,
                                     inout longint t_in, inout longint t_out);
        longint t1, t2, tmp;
        if (d == 0)
            return !(o < lo || o > hi);
        t1 = slab_quotient(lo - o, d);
        t2 = slab_quotient(hi - o, d);
        if (t1 > t2)
        begin
            tmp = t1;
            t1 = t2;
            t2 = tmp;
        end
        if (t1 > t_in)
            t_in = t1;
        if (t2 < t_out)
            t_out = t2;
        return t_in <= t_out;
    endfunction

    function automatic hit_word_t nearest_hit();
        hit_word_t w;
        longint    near, t_in, t_out;
        w = '0;
        case (action)
            ACT_CLEAR: stored = 0;
            ACT_ADD:
            begin
                if (stored >= NBOX)
                    w.table_full = 1'b1;
                else
                begin
                    lo_x[stored] = coord_a_x;
                    lo_y[stored] = coord_a_y;
                    lo_z[stored] = coord_a_z;
                    hi_x[stored] = coord_b_x;
                    hi_y[stored] = coord_b_y;
                    hi_z[stored] = coord_b_z;
                    stored++;
                end
            end
            ACT_CAST:
            begin
                near = max_t;
                for (int i = 0; i < stored; i++)
                begin
                    t_in  = 0;
                    t_out = HUGE;
                    if (!slab_pass(coord_a_x, coord_b_x, lo_x[i], hi_x[i], t_in, t_out))
                        continue;
                    if (!slab_pass(coord_a_y, coord_b_y, lo_y[i], hi_y[i], t_in, t_out))
                        continue;
                    if (!slab_pass(coord_a_z, coord_b_z, lo_z[i], hi_z[i], t_in, t_out))
                        continue;
                    if (t_in >= 0 && t_in < near)
                        near = t_in;
                end
                w.distance = near[DIST_W-1:0];
                w.hit      = near < longint'(max_t);
            end
            default: ;
        endcase
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hit_word_t want;
        if (!rst_n)
        begin
            stored = 0;
            errors = 0;
            expected_hits.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_hits = {expected_hits, nearest_hit()};
            if (out_valid && out_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (distance !== want.distance)
                    begin
                        $error("distance: expected %0h, got %0h", want.distance, distance);
                        errors++;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0b, got %0b", want.hit, hit);
                        errors++;
                    end
                    if (table_full !== want.table_full)
                    begin
                        $error("table_full: expected %0b, got %0b",
                               want.table_full, table_full);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives clear, add and cast words into the nearest ray/box hit block with
// random gaps and receiver stalls; a checker alongside predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import nrbh_pkg::*;

    localparam int CW         = DEF_COORD_W;
    localparam int NBOX       = DEF_MAX_BOXES;
    localparam int N_WORDS    = 1450;
    localparam int IDLE_LIMIT = 100000;
    localparam int ONE        = 1 << FRAC_BITS;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           action;
    logic signed [CW-1:0] coord_a_x, coord_a_y, coord_a_z;
    logic signed [CW-1:0] coord_b_x, coord_b_y, coord_b_z;
    logic [DIST_W-1:0]    max_t;
    logic                 out_valid;
    logic                 out_ready;
    logic [DIST_W-1:0]    distance;
    logic                 hit;
    logic                 table_full;
    int                   errors;
    int                   pending;
    int                   sent;
    int                   idle_cycles;
    bit                   calm;

    nearest_ray_box_hit DUT (.*);

    nrbh_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [CW-1:0] near_coord();
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32 * ONE)) - 16 * ONE;
    endfunction

    function automatic logic signed [CW-1:0] ray_dir();
        int r;
        r = $urandom_range(0, 19);
        if (r < 4)
            return '0;
        if (r == 4)
            return $urandom;
        return $signed($urandom_range(0, 4 * ONE)) - 2 * ONE;
    endfunction

    function automatic logic [DIST_W-1:0] ray_limit();
        int r;
        r = $urandom_range(0, 3);
        if (r < 2)
            return T_HUGE;
        if (r == 2)
            return DIST_W'($urandom);
        return DIST_W'($urandom_range(0, 24 * ONE));
    endfunction

    task automatic send(input logic [1:0] act,
                        input logic signed [CW-1:0] ax, ay, az, bx, by, bz,
                        input logic [DIST_W-1:0] mt);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action    <= act;
        coord_a_x <= ax;
        coord_a_y <= ay;
        coord_a_z <= az;
        coord_b_x <= bx;
        coord_b_y <= by;
        coord_b_z <= bz;
        max_t     <= mt;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic add_near_box();
        logic signed [CW-1:0] lx, ly, lz;
        lx = near_coord();
        ly = near_coord();
        lz = near_coord();
        if ($urandom_range(0, 9) == 0)
            send(ACT_ADD, lx, ly, lz, lx - ONE, ly + ONE, lz + ONE, DIST_W'($urandom));
        else
            send(ACT_ADD, lx, ly, lz,
                 lx + $urandom_range(0, 6 * ONE), ly + $urandom_range(0, 6 * ONE),
                 lz + $urandom_range(0, 6 * ONE), DIST_W'($urandom));
    endtask

    task automatic cast_near_ray();
        send(ACT_CAST, near_coord(), near_coord(), near_coord(),
             ray_dir(), ray_dir(), ray_dir(), ray_limit());
    endtask

    // receiver: long hold-off first, then random stalls
    initial
    begin
        int len;
        out_ready = 1'b0;
        @(posedge rst_n);
        repeat (500) @(negedge clk);
        forever
        begin
            len = gap_len();
            if (len > 0)
            begin
                out_ready <= 1'b0;
                repeat (len) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int r;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_CLEAR;
        coord_a_x = '0;
        coord_a_y = '0;
        coord_a_z = '0;
        coord_b_x = '0;
        coord_b_y = '0;
        coord_b_z = '0;
        max_t     = '0;
        sent      = 0;
        calm      = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(ACT_CLEAR, '1, '1, '1, '1, '1, '1, T_HUGE);
        send(ACT_CAST, 0, 0, 0, ONE, ONE, ONE, DIST_W'(24 * ONE));
        send(ACT_ADD, 0, 0, 0, ONE, ONE, ONE, '0);
        send(ACT_CAST, -2 * ONE, ONE / 2, ONE / 2, ONE, 0, 0, T_HUGE);
        send(ACT_CAST, -2 * ONE, 2 * ONE, ONE / 2, ONE, 0, 0, T_HUGE);
        send(ACT_CAST, 3 * ONE, ONE / 2, ONE / 2, -ONE, 0, 0, T_HUGE);
        send(ACT_CAST, ONE / 2, ONE / 2, ONE / 2, 3, -7, 5, T_HUGE);
        send(ACT_CAST, -2 * ONE, ONE / 2, ONE / 2, ONE, 0, 0, '0);
        send(ACT_CAST, -2 * ONE, ONE / 2, ONE / 2, ONE, 0, 0, DIST_W'(ONE));
        send(ACT_CAST, 32'sh8000_0000, ONE / 2, ONE / 2, 1, 0, 0, T_HUGE);
        send(ACT_CAST, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, T_HUGE);
        send(ACT_ADD, 2 * ONE, 0, 0, ONE, ONE, ONE, T_HUGE);
        send(ACT_CAST, -2 * ONE, ONE / 2, ONE / 2, 3 * ONE, ONE, 0, T_HUGE);
        send(ACT_CAST, ONE + ONE / 2, ONE / 2, ONE / 2, 0, ONE, 0, T_HUGE);
        send(ACT_UNUSED, '1, '1, '1, '1, '1, '1, T_HUGE);
        send(ACT_CLEAR, 0, 0, 0, 0, 0, 0, '0);
        for (int i = 0; i < NBOX; i++)
            add_near_box();
        send(ACT_ADD, 0, 0, 0, ONE, ONE, ONE, '0);
        send(ACT_CAST, 0, 0, 0, ONE, -ONE, ONE / 3, T_HUGE);
        send(ACT_CLEAR, 0, 0, 0, 0, 0, 0, '0);

        while (sent < N_WORDS)
        begin
            calm = (sent > 600 && sent < 800);
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                send(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, DIST_W'($urandom));
                repeat ($urandom_range(0, 6)) add_near_box();
                repeat ($urandom_range(1, 3)) cast_near_ray();
            end
            else
                send(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, DIST_W'($urandom));
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/nrbh_pkg.sv
rtl/core/nrbh_div.sv
rtl/core/nearest_ray_box_hit.sv
bench/nrbh_checker.sv
bench/testbench.sv
